>>> rtl/json_stream_validator_macros.svh
// ----------------------------------------------------------------------------
// json_stream_validator_macros.svh
// Assertion helpers shared by the checker files.
// ----------------------------------------------------------------------------
`ifndef JSON_STREAM_VALIDATOR_MACROS_SVH
`define JSON_STREAM_VALIDATOR_MACROS_SVH

// Clocked assertion, silenced while reset is asserted
`define JSV_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that also holds during reset
`define JSV_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/jsv_pkg.sv
// ----------------------------------------------------------------------------
// jsv_pkg
// Types, constants and character helpers of the JSON stream validator.
// ----------------------------------------------------------------------------
`default_nettype none

package jsv_pkg;

    localparam int MAX_NESTING = 512;
    localparam int OFFSET_BITS = 48;

    localparam int STACK_AW  = $clog2(MAX_NESTING);
    localparam int DEPTH_W   = $clog2(MAX_NESTING + 2);
    localparam int CFG_W     = 10;
    localparam int LIM_W     = (DEPTH_W > CFG_W) ? DEPTH_W : CFG_W;
    localparam int OUT_OFF_W = 48;
    localparam int DEPTH_LIMIT_RESET = 512;

    // Parse modes
    localparam logic [4:0] M_VALUE     = 5'd0;
    localparam logic [4:0] M_ARR_FIRST = 5'd1;
    localparam logic [4:0] M_OBJ_FIRST = 5'd2;
    localparam logic [4:0] M_KEY       = 5'd3;
    localparam logic [4:0] M_COLON     = 5'd4;
    localparam logic [4:0] M_AFTER     = 5'd5;
    localparam logic [4:0] M_STR       = 5'd6;
    localparam logic [4:0] M_ESC       = 5'd7;
    localparam logic [4:0] M_HEX       = 5'd8;
    localparam logic [4:0] M_UTF       = 5'd9;
    localparam logic [4:0] M_N_MINUS   = 5'd10;
    localparam logic [4:0] M_N_ZERO    = 5'd11;
    localparam logic [4:0] M_N_INT     = 5'd12;
    localparam logic [4:0] M_N_DOT     = 5'd13;
    localparam logic [4:0] M_N_FRAC    = 5'd14;
    localparam logic [4:0] M_N_E       = 5'd15;
    localparam logic [4:0] M_N_ESIGN   = 5'd16;
    localparam logic [4:0] M_N_EXP     = 5'd17;
    localparam logic [4:0] M_LIT       = 5'd18;
    localparam logic [4:0] M_DONE      = 5'd19;

    // Status and error codes
    localparam logic [3:0] ST_RUNNING    = 4'd0;
    localparam logic [3:0] ST_VALID      = 4'd1;
    localparam logic [3:0] ERR_KEY       = 4'd2;
    localparam logic [3:0] ERR_STRING    = 4'd3;
    localparam logic [3:0] ERR_UESC      = 4'd4;
    localparam logic [3:0] ERR_ESC       = 4'd5;
    localparam logic [3:0] ERR_UTF8      = 4'd6;
    localparam logic [3:0] ERR_NUMBER    = 4'd7;
    localparam logic [3:0] ERR_FRAC      = 4'd8;
    localparam logic [3:0] ERR_EXP       = 4'd9;
    localparam logic [3:0] ERR_DEPTH     = 4'd10;
    localparam logic [3:0] ERR_VALUE     = 4'd11;
    localparam logic [3:0] ERR_LITERAL   = 4'd12;
    localparam logic [3:0] ERR_COLON     = 4'd13;
    localparam logic [3:0] ERR_COMMA     = 4'd14;
    localparam logic [3:0] ERR_TRAILING  = 4'd15;

    // Root types
    localparam logic [2:0] RT_UNKNOWN = 3'd0;
    localparam logic [2:0] RT_OBJECT  = 3'd1;
    localparam logic [2:0] RT_ARRAY   = 3'd2;
    localparam logic [2:0] RT_STRING  = 3'd3;
    localparam logic [2:0] RT_NUMBER  = 3'd4;
    localparam logic [2:0] RT_BOOLEAN = 3'd5;
    localparam logic [2:0] RT_NULL    = 3'd6;

    // Byte-order mark progress
    localparam logic [1:0] BOM_START = 2'd0;
    localparam logic [1:0] BOM_EF    = 2'd1;
    localparam logic [1:0] BOM_EFBB  = 2'd2;
    localparam logic [1:0] BOM_DONE  = 2'd3;

    // Stack command from the parser
    typedef struct packed {
        logic push;
        logic pop;
        logic kind;   // 1 object, 0 array
    } stk_op_t;

    // One result beat
    typedef struct packed {
        logic [2:0]           root;
        logic [OUT_OFF_W-1:0] offset;
        logic [3:0]           status;
    } result_t;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == 8'h20) || (c == 8'h09) || (c == 8'h0d) || (c == 8'h0a);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_digit(c) || ((c >= 8'h61) && (c <= 8'h66)) ||
               ((c >= 8'h41) && (c <= 8'h46));
    endfunction

    // Letters of "truefalsenull"
    function automatic logic [7:0] lit_char(input logic [3:0] p);
        logic [7:0] r;
        case (p)
            4'd0:    r = 8'h74;
            4'd1:    r = 8'h72;
            4'd2:    r = 8'h75;
            4'd3:    r = 8'h65;
            4'd4:    r = 8'h66;
            4'd5:    r = 8'h61;
            4'd6:    r = 8'h6c;
            4'd7:    r = 8'h73;
            4'd8:    r = 8'h65;
            4'd9:    r = 8'h6e;
            4'd10:   r = 8'h75;
            4'd11:   r = 8'h6c;
            4'd12:   r = 8'h6c;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [OFFSET_BITS-1:0] off_inc(input logic [OFFSET_BITS-1:0] v);
        return (&v) ? v : v + OFFSET_BITS'(1);
    endfunction

endpackage

`default_nettype wire

>>> rtl/jsv_ram.sv
// ----------------------------------------------------------------------------
// jsv_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module jsv_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 512
) (
    input  wire                     clk,
    input  wire                     we,
    input  wire [$clog2(DEPTH)-1:0] waddr,
    input  wire [WIDTH-1:0]         wdata,
    input  wire [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> rtl/jsv_stack.sv
// ----------------------------------------------------------------------------
// jsv_stack
// Container-kind stack: top entry in a flop, lower entries in RAM, with the
// entry beneath the top prefetched every cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module jsv_stack (
    input  wire                         clk,
    input  wire                         rst_n,
    input  jsv_pkg::stk_op_t            op,
    input  wire [jsv_pkg::DEPTH_W-1:0]  depth,
    output logic                        top_kind
);

    logic                           top_reg;
    logic                           top_next;
    logic                           fwd_reg;
    logic                           fwd_data_reg;
    logic                           below;
    logic                           rd_data;
    logic [jsv_pkg::DEPTH_W-1:0]    depth_new;
    logic [jsv_pkg::DEPTH_W-1:0]    rd_idx;
    logic [jsv_pkg::DEPTH_W-1:0]    wr_idx;

    // Old top spills to its slot on a push; beneath-top is read for the new depth
    always_comb
    begin
        depth_new = depth;
        if (op.push)
        begin
            depth_new = depth + jsv_pkg::DEPTH_W'(1);
        end
        else if (op.pop)
        begin
            depth_new = depth - jsv_pkg::DEPTH_W'(1);
        end
        rd_idx = depth_new - jsv_pkg::DEPTH_W'(2);
        wr_idx = depth - jsv_pkg::DEPTH_W'(1);
        below  = fwd_reg ? fwd_data_reg : rd_data;
        top_next = top_reg;
        if (op.push)
        begin
            top_next = op.kind;
        end
        else if (op.pop)
        begin
            top_next = below;
        end
    end

    jsv_ram #(
        .WIDTH (1),
        .DEPTH (jsv_pkg::MAX_NESTING)
    ) u_ram (
        .clk   (clk),
        .we    (op.push && (depth != '0)),
        .waddr (wr_idx[jsv_pkg::STACK_AW-1:0]),
        .wdata (top_reg),
        .raddr (rd_idx[jsv_pkg::STACK_AW-1:0]),
        .rdata (rd_data)
    );

    // Forward the spilled entry for the cycle its write is still landing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= 1'b0;
        end
        else
        begin
            fwd_reg <= op.push;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg      <= top_next;
        fwd_data_reg <= top_reg;
    end

    assign top_kind = top_reg;

endmodule

`default_nettype wire

>>> rtl/jsv_core.sv
// ----------------------------------------------------------------------------
// jsv_core
// Byte parser: mode, counters, error latch and root type, one byte a cycle while accept is high.
// ----------------------------------------------------------------------------
`default_nettype none

module jsv_core (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         accept,
    input  wire                         cmd,
    input  wire [7:0]                   data_byte,
    input  wire                         cfg_we,
    input  wire [jsv_pkg::CFG_W-1:0]    cfg_data,
    input  wire                         top_kind,
    output jsv_pkg::stk_op_t            op,
    output logic [jsv_pkg::DEPTH_W-1:0] depth,
    output jsv_pkg::result_t            res
);

    localparam int OB = jsv_pkg::OFFSET_BITS;
    localparam int DW = jsv_pkg::DEPTH_W;

    logic [jsv_pkg::CFG_W-1:0] limit_reg;
    logic [4:0]  mode_reg,     mode_next;
    logic [DW-1:0] depth_reg,  depth_next;
    logic [1:0]  urem_reg,     urem_next;
    logic [2:0]  ucls_reg,     ucls_next;
    logic [2:0]  hex_reg,      hex_next;
    logic [3:0]  lit_reg,      lit_next;
    logic [1:0]  bom_reg,      bom_next;
    logic [3:0]  err_reg,      err_next;
    logic [OB-1:0] epos_reg,   epos_next;
    logic [2:0]  root_reg,     root_next;
    logic [OB-1:0] off_reg,    off_next;
    logic        key_reg,      key_next;
    logic        fin_reg,      fin_next;

    logic [7:0]  c;
    logic        feed;
    logic        start;
    logic        after;
    logic        do_close;
    logic        do_fail;
    logic [3:0]  fkind;
    logic [OB-1:0] fpos;
    logic [jsv_pkg::LIM_W-1:0] lim;
    logic [jsv_pkg::LIM_W-1:0] cfg_w;

    always_comb
    begin
        mode_next  = mode_reg;
        depth_next = depth_reg;
        urem_next  = urem_reg;
        ucls_next  = ucls_reg;
        hex_next   = hex_reg;
        lit_next   = lit_reg;
        bom_next   = bom_reg;
        err_next   = err_reg;
        epos_next  = epos_reg;
        root_next  = root_reg;
        off_next   = off_reg;
        key_next   = key_reg;
        fin_next   = fin_reg;
        op         = '0;
        feed       = 1'b0;
        start      = 1'b0;
        after      = 1'b0;
        do_close   = 1'b0;
        do_fail    = 1'b0;
        fkind      = jsv_pkg::ST_RUNNING;
        fpos       = '0;
        c          = cmd ? 8'h00 : data_byte;

        // Clamp the nesting limit
        cfg_w = jsv_pkg::LIM_W'(limit_reg);
        lim   = (cfg_w > jsv_pkg::LIM_W'(jsv_pkg::MAX_NESTING)) ?
                jsv_pkg::LIM_W'(jsv_pkg::MAX_NESTING) : cfg_w;

        if (accept && (err_reg == jsv_pkg::ST_RUNNING) && !fin_reg)
        begin
            // Skip the byte-order mark, then feed the parser
            if (!cmd)
            begin
                off_next = jsv_pkg::off_inc(off_reg);
                case (bom_reg)
                    jsv_pkg::BOM_START:
                    begin
                        if (c == 8'hef)
                        begin
                            bom_next = jsv_pkg::BOM_EF;
                        end
                        else
                        begin
                            bom_next = jsv_pkg::BOM_DONE;
                            feed     = 1'b1;
                        end
                    end
                    jsv_pkg::BOM_EF:
                    begin
                        if (c == 8'hbb)
                        begin
                            bom_next = jsv_pkg::BOM_EFBB;
                        end
                        else
                        begin
                            do_fail = 1'b1;
                            fkind   = jsv_pkg::ERR_VALUE;
                        end
                    end
                    jsv_pkg::BOM_EFBB:
                    begin
                        if (c == 8'hbf)
                        begin
                            bom_next = jsv_pkg::BOM_DONE;
                        end
                        else
                        begin
                            do_fail = 1'b1;
                            fkind   = jsv_pkg::ERR_VALUE;
                        end
                    end
                    default:
                    begin
                        feed = 1'b1;
                    end
                endcase
            end
            else
            begin
                fin_next = 1'b1;
                if ((bom_reg == jsv_pkg::BOM_EF) || (bom_reg == jsv_pkg::BOM_EFBB))
                begin
                    do_fail = 1'b1;
                    fkind   = jsv_pkg::ERR_VALUE;
                end
                else
                begin
                    bom_next = jsv_pkg::BOM_DONE;
                    feed     = 1'b1;
                end
            end

            // Per-mode step
            if (feed)
            begin
                fpos = off_reg;
                case (mode_reg)
                    jsv_pkg::M_VALUE, jsv_pkg::M_ARR_FIRST:
                    begin
                        if (!jsv_pkg::is_ws(c))
                        begin
                            if ((mode_reg == jsv_pkg::M_ARR_FIRST) && (c == 8'h5d))
                            begin
                                do_close = 1'b1;
                            end
                            else
                            begin
                                start = 1'b1;
                            end
                        end
                    end
                    jsv_pkg::M_OBJ_FIRST, jsv_pkg::M_KEY:
                    begin
                        if (!jsv_pkg::is_ws(c))
                        begin
                            if ((mode_reg == jsv_pkg::M_OBJ_FIRST) && (c == 8'h7d))
                            begin
                                do_close = 1'b1;
                            end
                            else if (c == 8'h22)
                            begin
                                key_next  = 1'b1;
                                mode_next = jsv_pkg::M_STR;
                            end
                            else
                            begin
                                do_fail = 1'b1;
                                fkind   = jsv_pkg::ERR_KEY;
                            end
                        end
                    end
                    jsv_pkg::M_COLON:
                    begin
                        if (!jsv_pkg::is_ws(c))
                        begin
                            if (c == 8'h3a)
                            begin
                                mode_next = jsv_pkg::M_VALUE;
                            end
                            else
                            begin
                                do_fail = 1'b1;
                                fkind   = jsv_pkg::ERR_COLON;
                            end
                        end
                    end
                    jsv_pkg::M_AFTER:
                    begin
                        after = 1'b1;
                    end
                    jsv_pkg::M_STR:
                    begin
                        if (c == 8'h22)
                        begin
                            mode_next = key_reg ? jsv_pkg::M_COLON : jsv_pkg::M_AFTER;
                        end
                        else if (c < 8'h20)
                        begin
                            do_fail = 1'b1;
                            fkind   = jsv_pkg::ERR_STRING;
                        end
                        else if (c == 8'h5c)
                        begin
                            mode_next = jsv_pkg::M_ESC;
                        end
                        else if (c >= 8'h80)
                        begin
                            if ((c >= 8'hc2) && (c <= 8'hf4))
                            begin
                                if (c <= 8'hdf)
                                begin
                                    urem_next = 2'd1;
                                end
                                else if (c <= 8'hef)
                                begin
                                    urem_next = 2'd2;
                                end
                                else
                                begin
                                    urem_next = 2'd3;
                                end
                                ucls_next = (c == 8'he0) ? 3'd1 :
                                            (c == 8'hed) ? 3'd2 :
                                            (c == 8'hf0) ? 3'd3 :
                                            (c == 8'hf4) ? 3'd4 : 3'd0;
                                mode_next = jsv_pkg::M_UTF;
                            end
                            else
                            begin
                                do_fail = 1'b1;
                                fkind   = jsv_pkg::ERR_UTF8;
                            end
                        end
                    end
                    jsv_pkg::M_ESC:
                    begin
                        if (c == 8'h75)
                        begin
                            hex_next  = 3'd4;
                            mode_next = jsv_pkg::M_HEX;
                        end
                        else if ((c == 8'h22) || (c == 8'h5c) || (c == 8'h2f) ||
                                 (c == 8'h62) || (c == 8'h66) || (c == 8'h6e) ||
                                 (c == 8'h72) || (c == 8'h74))
                        begin
                            mode_next = jsv_pkg::M_STR;
                        end
                        else
                        begin
                            do_fail = 1'b1;
                            fkind   = jsv_pkg::ERR_ESC;
                            fpos    = jsv_pkg::off_inc(off_reg);
                        end
                    end
                    jsv_pkg::M_HEX:
                    begin
                        if (!jsv_pkg::is_hex(c))
                        begin
                            do_fail = 1'b1;
                            fkind   = jsv_pkg::ERR_UESC;
                        end
                        else if (hex_reg <= 3'd1)
                        begin
                            hex_next  = 3'd0;
                            mode_next = jsv_pkg::M_STR;
                        end
                        else
                        begin
                            hex_next = hex_reg - 3'd1;
                        end
                    end
                    jsv_pkg::M_UTF:
                    begin
                        if ((c < 8'h80) || (c > 8'hbf) ||
                            ((ucls_reg == 3'd1) && (c < 8'ha0)) ||
                            ((ucls_reg == 3'd2) && (c > 8'h9f)) ||
                            ((ucls_reg == 3'd3) && (c < 8'h90)) ||
                            ((ucls_reg == 3'd4) && (c > 8'h8f)))
                        begin
                            do_fail = 1'b1;
                            fkind   = jsv_pkg::ERR_UTF8;
                        end
                        else
                        begin
                            ucls_next = 3'd0;
                            if (urem_reg <= 2'd1)
                            begin
                                urem_next = 2'd0;
                                mode_next = jsv_pkg::M_STR;
                            end
                            else
                            begin
                                urem_next = urem_reg - 2'd1;
                            end
                        end
                    end
                    jsv_pkg::M_N_MINUS:
                    begin
                        if (c == 8'h30)
                        begin
                            mode_next = jsv_pkg::M_N_ZERO;
                        end
                        else if (jsv_pkg::is_digit(c))
                        begin
                            mode_next = jsv_pkg::M_N_INT;
                        end
                        else
                        begin
                            do_fail = 1'b1;
                            fkind   = jsv_pkg::ERR_NUMBER;
                        end
                    end
                    jsv_pkg::M_N_ZERO, jsv_pkg::M_N_INT:
                    begin
                        if ((mode_reg == jsv_pkg::M_N_INT) && jsv_pkg::is_digit(c))
                        begin
                            mode_next = mode_reg;
                        end
                        else if (c == 8'h2e)
                        begin
                            mode_next = jsv_pkg::M_N_DOT;
                        end
                        else if ((c == 8'h65) || (c == 8'h45))
                        begin
                            mode_next = jsv_pkg::M_N_E;
                        end
                        else
                        begin
                            after = 1'b1;
                        end
                    end
                    jsv_pkg::M_N_DOT:
                    begin
                        if (jsv_pkg::is_digit(c))
                        begin
                            mode_next = jsv_pkg::M_N_FRAC;
                        end
                        else
                        begin
                            do_fail = 1'b1;
                            fkind   = jsv_pkg::ERR_FRAC;
                        end
                    end
                    jsv_pkg::M_N_FRAC:
                    begin
                        if (jsv_pkg::is_digit(c))
                        begin
                            mode_next = mode_reg;
                        end
                        else if ((c == 8'h65) || (c == 8'h45))
                        begin
                            mode_next = jsv_pkg::M_N_E;
                        end
                        else
                        begin
                            after = 1'b1;
                        end
                    end
                    jsv_pkg::M_N_E:
                    begin
                        if ((c == 8'h2b) || (c == 8'h2d))
                        begin
                            mode_next = jsv_pkg::M_N_ESIGN;
                        end
                        else if (jsv_pkg::is_digit(c))
                        begin
                            mode_next = jsv_pkg::M_N_EXP;
                        end
                        else
                        begin
                            do_fail = 1'b1;
                            fkind   = jsv_pkg::ERR_EXP;
                        end
                    end
                    jsv_pkg::M_N_ESIGN:
                    begin
                        if (jsv_pkg::is_digit(c))
                        begin
                            mode_next = jsv_pkg::M_N_EXP;
                        end
                        else
                        begin
                            do_fail = 1'b1;
                            fkind   = jsv_pkg::ERR_EXP;
                        end
                    end
                    jsv_pkg::M_N_EXP:
                    begin
                        if (!jsv_pkg::is_digit(c))
                        begin
                            after = 1'b1;
                        end
                    end
                    jsv_pkg::M_LIT:
                    begin
                        if ((lit_reg < 4'd13) && (c == jsv_pkg::lit_char(lit_reg)))
                        begin
                            lit_next = lit_reg + 4'd1;
                            if ((lit_reg == 4'd3) || (lit_reg == 4'd8) || (lit_reg == 4'd12))
                            begin
                                mode_next = jsv_pkg::M_AFTER;
                            end
                        end
                        else
                        begin
                            do_fail = 1'b1;
                            fkind   = jsv_pkg::ERR_LITERAL;
                        end
                    end
                    default:
                    begin
                        mode_next = mode_reg;
                    end
                endcase
            end

            // Begin a new value
            if (start)
            begin
                if (jsv_pkg::LIM_W'(depth_reg) > lim)
                begin
                    do_fail = 1'b1;
                    fkind   = jsv_pkg::ERR_DEPTH;
                end
                else if ((c == 8'h7b) || (c == 8'h5b))
                begin
                    if (depth_reg == '0)
                    begin
                        root_next = (c == 8'h7b) ? jsv_pkg::RT_OBJECT : jsv_pkg::RT_ARRAY;
                    end
                    op.push    = 1'b1;
                    op.kind    = (c == 8'h7b);
                    depth_next = depth_reg + DW'(1);
                    mode_next  = (c == 8'h7b) ? jsv_pkg::M_OBJ_FIRST : jsv_pkg::M_ARR_FIRST;
                end
                else if (c == 8'h22)
                begin
                    if (depth_reg == '0)
                    begin
                        root_next = jsv_pkg::RT_STRING;
                    end
                    key_next  = 1'b0;
                    mode_next = jsv_pkg::M_STR;
                end
                else if ((c == 8'h2d) || jsv_pkg::is_digit(c))
                begin
                    if (depth_reg == '0)
                    begin
                        root_next = jsv_pkg::RT_NUMBER;
                    end
                    mode_next = (c == 8'h2d) ? jsv_pkg::M_N_MINUS :
                                (c == 8'h30) ? jsv_pkg::M_N_ZERO : jsv_pkg::M_N_INT;
                end
                else if ((c == 8'h74) || (c == 8'h66) || (c == 8'h6e))
                begin
                    if (depth_reg == '0)
                    begin
                        root_next = (c == 8'h6e) ? jsv_pkg::RT_NULL : jsv_pkg::RT_BOOLEAN;
                    end
                    lit_next  = (c == 8'h74) ? 4'd1 : (c == 8'h66) ? 4'd5 : 4'd10;
                    mode_next = jsv_pkg::M_LIT;
                end
                else
                begin
                    do_fail = 1'b1;
                    fkind   = jsv_pkg::ERR_VALUE;
                end
            end

            // After a complete value: separator, closer or end
            if (after)
            begin
                mode_next = jsv_pkg::M_AFTER;
                if (!jsv_pkg::is_ws(c))
                begin
                    if (depth_reg == '0)
                    begin
                        if (cmd)
                        begin
                            mode_next = jsv_pkg::M_DONE;
                        end
                        else
                        begin
                            do_fail = 1'b1;
                            fkind   = jsv_pkg::ERR_TRAILING;
                        end
                    end
                    else if (c == (top_kind ? 8'h7d : 8'h5d))
                    begin
                        do_close = 1'b1;
                    end
                    else if (c == 8'h2c)
                    begin
                        mode_next = top_kind ? jsv_pkg::M_KEY : jsv_pkg::M_VALUE;
                    end
                    else
                    begin
                        do_fail = 1'b1;
                        fkind   = jsv_pkg::ERR_COMMA;
                    end
                end
            end

            // Pop a container
            if (do_close)
            begin
                op.pop     = 1'b1;
                depth_next = depth_reg - DW'(1);
                mode_next  = jsv_pkg::M_AFTER;
            end

            if (cmd)
            begin
                mode_next = jsv_pkg::M_DONE;
            end

            // Latch the first error
            if (do_fail)
            begin
                err_next  = fkind;
                epos_next = fpos;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= jsv_pkg::CFG_W'(jsv_pkg::DEPTH_LIMIT_RESET);
            mode_reg  <= jsv_pkg::M_VALUE;
            depth_reg <= '0;
            urem_reg  <= '0;
            ucls_reg  <= '0;
            hex_reg   <= '0;
            lit_reg   <= '0;
            bom_reg   <= jsv_pkg::BOM_START;
            err_reg   <= jsv_pkg::ST_RUNNING;
            epos_reg  <= '0;
            root_reg  <= jsv_pkg::RT_UNKNOWN;
            off_reg   <= '0;
            key_reg   <= 1'b0;
            fin_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                limit_reg <= cfg_data;
            end
            mode_reg  <= mode_next;
            depth_reg <= depth_next;
            urem_reg  <= urem_next;
            ucls_reg  <= ucls_next;
            hex_reg   <= hex_next;
            lit_reg   <= lit_next;
            bom_reg   <= bom_next;
            err_reg   <= err_next;
            epos_reg  <= epos_next;
            root_reg  <= root_next;
            off_reg   <= off_next;
            key_reg   <= key_next;
            fin_reg   <= fin_next;
        end
    end

    // Result of this beat
    always_comb
    begin
        res.status = (err_next != jsv_pkg::ST_RUNNING) ? err_next :
                     fin_next ? jsv_pkg::ST_VALID : jsv_pkg::ST_RUNNING;
        res.offset = jsv_pkg::OUT_OFF_W'(epos_next);
        res.root   = root_next;
    end

    assign depth = depth_reg;

endmodule

`default_nettype wire

>>> rtl/jsv_outbuf.sv
// ----------------------------------------------------------------------------
// jsv_outbuf
// Output register with a skid stage, so input and output stall separately.
// ----------------------------------------------------------------------------
`default_nettype none

module jsv_outbuf (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 push,
    input  jsv_pkg::result_t    res,
    output logic                in_ready,
    output logic                out_valid,
    input  wire                 out_ready,
    output jsv_pkg::result_t    out_res
);

    logic             ov_reg, ov_next;
    logic             sv_reg, sv_next;
    jsv_pkg::result_t od_reg, od_next;
    jsv_pkg::result_t sd_reg, sd_next;

    // Advance skid into the output register, or park a beat in the skid
    always_comb
    begin
        ov_next = ov_reg;
        sv_next = sv_reg;
        od_next = od_reg;
        sd_next = sd_reg;
        if (!ov_reg || out_ready)
        begin
            if (sv_reg)
            begin
                od_next = sd_reg;
                ov_next = 1'b1;
                sv_next = 1'b0;
            end
            else
            begin
                od_next = res;
                ov_next = push;
            end
        end
        else if (push)
        begin
            sd_next = res;
            sv_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
            sv_reg <= 1'b0;
        end
        else
        begin
            ov_reg <= ov_next;
            sv_reg <= sv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        od_reg <= od_next;
        sd_reg <= sd_next;
    end

    assign in_ready  = !sv_reg;
    assign out_valid = ov_reg;
    assign out_res   = od_reg;

endmodule

`default_nettype wire

>>> rtl/json_stream_validator.sv
// ----------------------------------------------------------------------------
// json_stream_validator
// Byte-at-a-time JSON syntax checker with a RAM-held container stack.
// ----------------------------------------------------------------------------
// Channel   Direction  Beat contents
// s_*       in         tdata: data byte; tuser: end-of-document flag
// m_*       out        tdata: status, error offset, root type
// cfg_*     in         cfg_data: nesting depth limit
//
// One byte per cycle while s_tready is high; each result is registered before it leaves.
// The stack top sits in a flop and the entry beneath it is prefetched from
// the RAM each cycle, so a close can follow a close with no bubble.
// Reset clears all control state; the stack RAM needs no clearing pass.
// A stalled output parks one beat in a skid stage before s_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module json_stream_validator (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       s_tvalid,
    output logic                      s_tready,
    input  wire [7:0]                 s_tdata,   // [7:0] data_byte
    input  wire                       s_tuser,   // [0] cmd
    output logic                      m_tvalid,
    input  wire                       m_tready,
    output logic [55:0]               m_tdata,   // [3:0] status, [51:4] error_offset,
                                                 // [54:52] root_type, [55] zero
    input  wire                       cfg_valid,
    output logic                      cfg_ready,
    input  wire [jsv_pkg::CFG_W-1:0]  cfg_data
);

    logic                          accept;
    jsv_pkg::stk_op_t              op;
    logic [jsv_pkg::DEPTH_W-1:0]   depth;
    logic                          top_kind;
    jsv_pkg::result_t              res;
    jsv_pkg::result_t              out_res;

    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    jsv_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .cmd       (s_tuser),
        .data_byte (s_tdata),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .top_kind  (top_kind),
        .op        (op),
        .depth     (depth),
        .res       (res)
    );

    jsv_stack u_stack (
        .clk      (clk),
        .rst_n    (rst_n),
        .op       (op),
        .depth    (depth),
        .top_kind (top_kind)
    );

    jsv_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .res       (res),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    // Pack the result beat
    assign m_tdata = {1'b0, out_res.root, out_res.offset, out_res.status};

endmodule

`default_nettype wire

>>> rtl/jsv_checker.sv
// ----------------------------------------------------------------------------
// jsv_checker
// Port-level checks of the validator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "json_stream_validator_macros.svh"

module jsv_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        s_tvalid,
    input wire        s_tready,
    input wire [7:0]  s_tdata,
    input wire        s_tuser,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [55:0] m_tdata,
    input wire        cfg_valid,
    input wire        cfg_ready,
    input wire [9:0]  cfg_data
);

    // Hold a stalled result
    `JSV_ASSERT(a_hold_valid, m_tvalid && !m_tready |=> m_tvalid, "stalled beat dropped")
    // A beat taken into an empty output shows up next cycle
    `JSV_ASSERT(a_latency, s_tvalid && s_tready && !m_tvalid |=> m_tvalid, "result missing")
    // Input only back-pressures while a result waits
    `JSV_ASSERT(a_backpressure, !s_tready |-> m_tvalid, "input stalled with no result")
    // Configuration is never refused
    `JSV_ASSERT_ALWAYS(a_cfg_ready, rst_n |-> cfg_ready, "config write refused")

endmodule

bind json_stream_validator jsv_checker u_jsv_checker (.*);

`default_nettype wire
